FILE: rtl/core/mjc_pkg.sv
package mjc_pkg;

    typedef struct packed {
        logic [31:0] magnitude;
        logic        last;
    } in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [5:0] point_index;
        logic       end_of_line;
        logic       overflow;
    } out_t;

    typedef enum logic [2:0] {
        SEG_BLUE,
        SEG_CYAN,
        SEG_MID,
        SEG_YEL,
        SEG_RED,
        SEG_FLAT
    } seg_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic setup;
        logic div;
        logic advance;
        logic clear_line;
    } ctl_cmd_t;

    typedef struct packed {
        logic div_last;
        logic last_point;
    } ctl_sts_t;

    localparam int QUOT_BITS = 8;

endpackage

FILE: rtl/core/mjc_ctrl.sv
module mjc_ctrl
    import mjc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_last,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output ctl_cmd_t cmd,
    input  ctl_sts_t sts
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_SETUP = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (sts.last_point)
                    begin
                        cmd.clear_line = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/mjc_datapath.sv
module mjc_datapath
    import mjc_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int MAG_WIDTH  = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  in_t      in_item,
    output out_t     out_item,
    input  ctl_cmd_t cmd,
    output ctl_sts_t sts
);

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int MW = MAG_WIDTH;
    localparam int NW = MAG_WIDTH + 14;
    localparam int SW = $clog2(QUOT_BITS);

    logic [MW-1:0] m_in;
    logic [MW-1:0] mem [MAX_POINTS];

    logic [CW-1:0]        count_reg;
    logic [MW-1:0]        min_reg;
    logic [MW-1:0]        max_reg;
    logic                 ovf_reg;
    logic [IW-1:0]        idx_reg;
    logic [MW-1:0]        rd_reg;
    seg_t                 seg_reg, seg_next;
    logic [NW-1:0]        rem_reg, rem_next;
    logic [NW-1:0]        dsh_reg, den_next;
    logic [QUOT_BITS-1:0] q_reg;
    logic [SW-1:0]        step_reg;

    logic [NW-1:0] d_w, t_w, t20_w;
    logic [8:0]    sum128, mid_b;

    generate
        if (MW >= 32)
        begin : g_wide
            assign m_in = MW'(in_item.magnitude);
        end
        else
        begin : g_narrow
            assign m_in = in_item.magnitude[MW-1:0];
        end
    endgenerate

    // line bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (count_reg < CW'(MAX_POINTS))
                begin
                    count_reg <= count_reg + 1'b1;
                    if (m_in < min_reg)
                    begin
                        min_reg <= m_in;
                    end
                    if (m_in > max_reg)
                    begin
                        max_reg <= m_in;
                    end
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.clear_line)
            begin
                count_reg <= '0;
                min_reg   <= '1;
                max_reg   <= '0;
                ovf_reg   <= 1'b0;
                idx_reg   <= '0;
            end
            else if (cmd.advance)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.setup)
            begin
                step_reg <= '0;
            end
            else if (cmd.div)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && (count_reg < CW'(MAX_POINTS)))
        begin
            mem[count_reg[IW-1:0]] <= m_in;
        end
        if (cmd.rd)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    // segment select and ramp numerator
    always_comb
    begin
        d_w      = NW'(max_reg - min_reg);
        t_w      = NW'(rd_reg - min_reg);
        t20_w    = t_w * NW'(20);
        seg_next = SEG_FLAT;
        rem_next = '0;
        den_next = NW'(1);
        priority if (max_reg <= min_reg)
        begin
            seg_next = SEG_FLAT;
        end
        else if (t20_w <= d_w * NW'(4))
        begin
            seg_next = SEG_BLUE;
            rem_next = t_w * NW'(635);
            den_next = d_w;
        end
        else if (t20_w <= d_w * NW'(7))
        begin
            seg_next = SEG_CYAN;
            rem_next = (t20_w - d_w * NW'(4)) * NW'(85);
            den_next = d_w;
        end
        else if (t20_w <= d_w * NW'(13))
        begin
            seg_next = SEG_MID;
            rem_next = (t20_w - d_w * NW'(7)) * NW'(255);
            den_next = d_w * NW'(6);
        end
        else if (t20_w <= d_w * NW'(16))
        begin
            seg_next = SEG_YEL;
            rem_next = (d_w * NW'(16) - t20_w) * NW'(85);
            den_next = d_w;
        end
        else
        begin
            seg_next = SEG_RED;
            rem_next = (d_w - t_w) * NW'(635);
            den_next = d_w;
        end
    end

    // restoring divide, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            seg_reg <= seg_next;
            rem_reg <= rem_next;
            dsh_reg <= den_next << (QUOT_BITS - 1);
            q_reg   <= '0;
        end
        else if (cmd.div)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[QUOT_BITS-2:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[QUOT_BITS-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign sts.div_last   = (step_reg == SW'(QUOT_BITS - 1));
    assign sts.last_point = ((CW'(idx_reg) + 1'b1) == count_reg);

    assign sum128 = 9'd128 + {1'b0, q_reg};
    assign mid_b  = 9'd255 - {1'b0, q_reg} - {8'd0, (rem_reg != '0)};

    always_comb
    begin
        out_item             = '0;
        out_item.point_index = 6'(idx_reg);
        out_item.end_of_line = sts.last_point;
        out_item.overflow    = ovf_reg;
        unique case (seg_reg)
            SEG_BLUE:
            begin
                out_item.blue = sum128[8] ? 8'hff : sum128[7:0];
            end
            SEG_CYAN:
            begin
                out_item.green = q_reg;
                out_item.blue  = 8'hff;
            end
            SEG_MID:
            begin
                out_item.red   = q_reg;
                out_item.green = 8'hff;
                out_item.blue  = mid_b[8] ? 8'h00 : mid_b[7:0];
            end
            SEG_YEL:
            begin
                out_item.red   = 8'hff;
                out_item.green = q_reg;
            end
            SEG_RED:
            begin
                out_item.red = sum128[8] ? 8'hff : sum128[7:0];
            end
            SEG_FLAT:
            begin
                out_item.blue = 8'd128;
            end
            default:
            begin
                out_item.blue = 8'd128;
            end
        endcase
    end

endmodule

FILE: rtl/core/magnitude_jet_colormap.sv
// Loads a line of magnitudes one per cycle (up to MAX_POINTS, extras dropped and
// flagged), then on the request marked last emits one jet-map RGB color per stored
// point in load order. Each color passes a store read, a setup step, the 8-bit
// bit-serial ramp divider and the output state, which holds while the output is
// stalled; the input is stalled while colors drain.
module magnitude_jet_colormap
    import mjc_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int MAG_WIDTH  = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    mjc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_data.last),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    mjc_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .MAG_WIDTH  (MAG_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_data),
        .out_item (out_data),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
